// ===== design/rsm_pkg.sv =====
// Package: shared types and constants for the random sample multiset.
package rsm_pkg;

   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int VAL_W       = 32;
   localparam int RND_W       = 16;
   localparam int DIV_STEPS   = RND_W;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_ADDR,
      S_SCAN_DATA,
      S_INS_WRITE,
      S_REM_LAST,
      S_REM_WRITE,
      S_DIV,
      S_SAMP_ADDR,
      S_SAMP_DATA,
      S_RESPOND
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;        // capture request
      logic scan_start;  // reset scan index
      logic scan_read;   // issue read at scan index
      logic scan_eval;   // evaluate returned scan data, advance index
      logic ins_write;   // write new slot at count
      logic last_read;   // read last slot
      logic rem_write;   // move last slot into found place
      logic div_start;   // start modulo
      logic div_step;    // one restoring step
      logic samp_read;   // read picked slot
      logic samp_take;   // capture sampled value
      logic set_full;    // flag refused insert
      logic set_empty;   // flag empty sample
      logic respond;     // pulse result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       scan_done;
      logic       found;
      logic       div_done;
   } stat_type;

endpackage

// ===== design/rsm_ctrl.sv =====
// Controller: sequences scans, writes and the modulo for one item.
module rsm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rsm_pkg::stat_type stat,
   output rsm_pkg::cmd_type  cmd
);
   import rsm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_SCAN_ADDR;
         S_SCAN_ADDR: begin
            if (stat.op == OP_INSERT && stat.full)       state_in = S_RESPOND;
            else if (stat.op == OP_SAMPLE && stat.empty) state_in = S_RESPOND;
            else if (stat.op == OP_SAMPLE)               state_in = S_DIV;
            else if (stat.op != OP_INSERT && stat.op != OP_REMOVE)
               state_in = S_RESPOND;
            else if (stat.scan_done)
               state_in = (stat.op == OP_INSERT) ? S_INS_WRITE : S_REM_LAST;
            else state_in = S_SCAN_DATA;
         end
         S_SCAN_DATA: state_in = S_SCAN_ADDR;
         S_INS_WRITE: state_in = S_RESPOND;
         S_REM_LAST:  state_in = stat.found ? S_REM_WRITE : S_RESPOND;
         S_REM_WRITE: state_in = S_RESPOND;
         S_DIV:       if (stat.div_done) state_in = S_SAMP_ADDR;
         S_SAMP_ADDR: state_in = S_SAMP_DATA;
         S_SAMP_DATA: state_in = S_RESPOND;
         S_RESPOND:   state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            cmd.load       = start;
            cmd.scan_start = start;
            cmd.div_start  = start;
         end
         S_SCAN_ADDR: begin
            cmd.set_full  = (stat.op == OP_INSERT) && stat.full;
            cmd.set_empty = (stat.op == OP_SAMPLE) && stat.empty;
            cmd.scan_read = (stat.op == OP_INSERT || stat.op == OP_REMOVE)
                            && !stat.scan_done && !(stat.op == OP_INSERT && stat.full);
         end
         S_SCAN_DATA: cmd.scan_eval = 1'b1;
         S_INS_WRITE: cmd.ins_write = 1'b1;
         S_REM_LAST:  cmd.last_read = 1'b1;
         S_REM_WRITE: cmd.rem_write = 1'b1;
         S_DIV:       cmd.div_step  = !stat.div_done;
         S_SAMP_ADDR: cmd.samp_read = 1'b1;
         S_SAMP_DATA: cmd.samp_take = 1'b1;
         S_RESPOND:   cmd.respond   = 1'b1;
         default:     cmd = '0;
      endcase
   end

endmodule

// ===== design/rsm_datapath.sv =====
// Datapath: slot memories, scan logic, modulo unit and result registers.
module rsm_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rsm_pkg::cmd_type             cmd,
   output rsm_pkg::stat_type            stat,
   input  logic [1:0]                   req_operation,
   input  logic signed [31:0]           req_item_value,
   input  logic [15:0]                  req_random_word,
   output logic                         rsp_valid,
   output logic                         rsp_hit_flag,
   output logic signed [31:0]           rsp_sampled_value,
   output logic [1:0]                   rsp_status
);
   import rsm_pkg::*;

   logic [VAL_W-1:0] mem_value [CAPACITY];
   logic [IDX_W-1:0] mem_rank  [CAPACITY];

   logic [1:0]       op_ff;
   logic [VAL_W-1:0] val_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [IDX_W-1:0] copies_ff;
   logic             found_ff;
   logic [IDX_W-1:0] best_ff;
   logic [IDX_W-1:0] where_ff;
   logic [VAL_W-1:0] rd_value_ff;
   logic [IDX_W-1:0] rd_rank_ff;
   logic [RND_W-1:0] quot_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [$clog2(DIV_STEPS+1)-1:0] dcnt_ff;
   logic             hit_ff;
   logic [VAL_W-1:0] samp_ff;
   logic [1:0]       status_ff;
   logic             valid_ff;

   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] last_idx;
   logic [CNT_W:0]   trial;

   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign trial    = {rem_ff, quot_ff[RND_W-1]} - {1'b0, count_ff};

   always_comb begin
      rd_addr = scan_ff[IDX_W-1:0];
      if (cmd.last_read)      rd_addr = last_idx;
      else if (cmd.samp_read) rd_addr = rem_ff[IDX_W-1:0];
   end

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.ins_write) begin
         mem_value[count_ff[IDX_W-1:0]] <= val_ff;
         mem_rank[count_ff[IDX_W-1:0]]  <= copies_ff;
      end else if (cmd.rem_write) begin
         mem_value[where_ff] <= rd_value_ff;
         mem_rank[where_ff]  <= rd_rank_ff;
      end
      if (cmd.scan_read || cmd.last_read || cmd.samp_read) begin
         rd_value_ff <= mem_value[rd_addr];
         rd_rank_ff  <= mem_rank[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.respond;
         if (cmd.ins_write)      count_ff <= count_ff + CNT_W'(1);
         else if (cmd.rem_write) count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Scan, modulo and result payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         val_ff    <= req_item_value;
         hit_ff    <= 1'b0;
         samp_ff   <= '0;
         status_ff <= ST_OK;
      end
      if (cmd.scan_start) begin
         scan_ff   <= '0;
         copies_ff <= '0;
         found_ff  <= 1'b0;
         best_ff   <= '0;
         where_ff  <= '0;
      end
      if (cmd.scan_eval) begin
         scan_ff <= scan_ff + CNT_W'(1);
         if (rd_value_ff == val_ff) begin
            copies_ff <= copies_ff + IDX_W'(1);
            if (!found_ff || rd_rank_ff > best_ff) begin
               found_ff <= 1'b1;
               best_ff  <= rd_rank_ff;
               where_ff <= scan_ff[IDX_W-1:0];
            end
         end
      end
      if (cmd.div_start) begin
         quot_ff <= req_random_word;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         quot_ff <= {quot_ff[RND_W-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + ($bits(dcnt_ff))'(1);
         if (!trial[CNT_W]) rem_ff <= trial[CNT_W-1:0];
         else               rem_ff <= {rem_ff[CNT_W-2:0], quot_ff[RND_W-1]};
      end
      if (cmd.ins_write) hit_ff <= (copies_ff == '0);
      if (cmd.rem_write) hit_ff <= 1'b1;
      if (cmd.set_full)  status_ff <= ST_FULL;
      if (cmd.set_empty) status_ff <= ST_EMPTY;
      if (cmd.samp_take) samp_ff <= rd_value_ff;
   end

   assign stat.op        = op_ff;
   assign stat.full      = (count_ff >= CNT_W'(CAPACITY));
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_done = (scan_ff >= count_ff);
   assign stat.found     = found_ff;
   assign stat.div_done  = (dcnt_ff == ($bits(dcnt_ff))'(DIV_STEPS));

   assign rsp_valid         = valid_ff;
   assign rsp_hit_flag      = hit_ff;
   assign rsp_sampled_value = samp_ff;
   assign rsp_status        = status_ff;

endmodule

// ===== design/random_sample_multiset.sv =====
// Top level: bounded multiset with insert, remove and random sample.
//   channel | ports                                   | handshake
//   request | req_operation/item_value/random_word     | start & !busy
//   result  | rsp_hit_flag/sampled_value/status        | rsp_valid, one cycle
// Insert and remove scan the slot memory with a read state and an evaluate
// state per occupied slot; a refused insert answers without a scan.
// Sample runs a 16-step restoring modulo before it reads the picked slot.
// Reset empties the store at once; slot contents are not cleared.
// The result is shown for one cycle; the receiver cannot stall it.
module random_sample_multiset (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_item_value,
   input  logic [15:0]        req_random_word,
   output logic               rsp_valid,
   output logic               rsp_hit_flag,
   output logic signed [31:0] rsp_sampled_value,
   output logic [1:0]         rsp_status
);
   import rsm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rsm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   rsm_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_operation(req_operation), .req_item_value(req_item_value),
      .req_random_word(req_random_word), .rsp_valid(rsp_valid),
      .rsp_hit_flag(rsp_hit_flag), .rsp_sampled_value(rsp_sampled_value),
      .rsp_status(rsp_status)
   );

endmodule

// ===== design/rsm_checker.sv =====
// Checker: port-level properties of the multiset, bound to the top level.
module rsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_hit_flag,
   input logic signed [31:0] rsp_sampled_value,
   input logic [1:0]         rsp_status
);
   import rsm_pkg::*;

   // Accepted item makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after accept");

   // Result falls at the end of an item.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // Result is a single-cycle pulse.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result longer than a cycle");

   // Error status never comes with a hit or a value.
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_hit_flag && rsp_sampled_value == 0)
      else $error("error with payload");

endmodule

bind random_sample_multiset rsm_checker u_rsm_checker (.*);
